// ===== hdl/abad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package abad_pkg;

  typedef struct packed {
    logic mode;
    logic coded_bit;
    logic start_req;
  } in_t;

  typedef struct packed {
    logic symbol;
    logic symbol_valid;
    logic last;
    logic need_bit;
    logic error;
  } out_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } arith_req_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_TAG,
    PH_DECODE
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_NORM,
    ST_FIN
  } state_e;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 30;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_ZERO = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_ONE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TOTAL  = 2'd2;

  localparam int CountW = 32;
  localparam int TotalW = 33;
  localparam int InitW = 16;

endpackage
`default_nettype wire

// ===== hdl/abad_arith.sv =====
`timescale 1ns / 1ps
`default_nettype none
module abad_arith #(
  parameter int PW = 66,
  parameter int DW = 33
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire abad_pkg::arith_req_t   req_i,
  input  wire logic [PW-1:0]          a_i,
  input  wire logic [DW-1:0]          b_i,
  output logic      [PW-1:0]          res_o,
  output logic                        done_o
);

  localparam int CntW = $clog2(PW + 1);
  localparam logic [CntW-1:0] MulLast = CntW'(DW - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(PW - 1);

  logic                busy_q, done_q;
  abad_pkg::op_e       op_q;
  logic [CntW-1:0]     cnt_q;
  logic [PW-1:0]       acc_q, a_q;
  logic [DW-1:0]       b_q, rem_q;

  logic [PW-1:0]       sum;
  logic [DW:0]         sh;
  logic [DW+1:0]       diff;
  logic                ge, last;

  always_comb begin
    sum  = acc_q + (b_q[0] ? a_q : '0);
    sh   = {rem_q, a_q[PW-1]};
    diff = {1'b0, sh} - {2'b00, b_q};
    ge   = ~diff[DW+1];
    last = (op_q == abad_pkg::OP_MUL) ? (cnt_q == MulLast) : (cnt_q == DivLast);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= abad_pkg::OP_MUL;
      cnt_q  <= '0;
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= '0;
        acc_q  <= '0;
        rem_q  <= '0;
        a_q    <= a_i;
        b_q    <= b_i;
      end else if (busy_q) begin
        if (op_q == abad_pkg::OP_MUL) begin
          acc_q <= sum;
          a_q   <= {a_q[PW-2:0], 1'b0};
          b_q   <= {1'b0, b_q[DW-1:1]};
        end else begin
          // restoring step, quotient bits shift in from the bottom
          rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
          a_q   <= {a_q[PW-2:0], ge};
        end
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o  = (op_q == abad_pkg::OP_MUL) ? acc_q : a_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== hdl/adaptive_binary_arithmetic_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o   | in_data_i (mode, coded_bit, start_req)
// out     | output    | out_valid_o/out_ready_i | out_data_o (symbol .. error)
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// header, tag, rescale and idle items: the result is loaded in the cycle after the transfer, through ST_FIN
// a decode item steps through ST_CHECK, ST_MUL1, ST_DIV1, ST_MUL2, ST_DIV2 and ST_NORM to ST_FIN,
// PW = PRECISION + 34, DW = max(PRECISION + 1, 33): two DW-step multiplies and
// two PW-step divides, one bit a cycle through the shared shift-add/subtract unit
// one item at a time; the next is taken the cycle after the result transfer at the earliest
// reset is asynchronous, active low, and leaves the block idle with default config
module adaptive_binary_arithmetic_decoder #(
  parameter int PRECISION = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire abad_pkg::in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output abad_pkg::out_t                         out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [abad_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [abad_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int P    = PRECISION;
  localparam int RW   = P + 1;
  localparam int TW   = abad_pkg::TotalW;
  localparam int CW   = abad_pkg::CountW;
  localparam int DW   = (RW > TW) ? RW : TW;
  localparam int PW   = RW + TW;
  localparam int HW   = P - 1;
  localparam int SLW  = P + 2;
  localparam int PSW  = $clog2(P + 1);
  localparam logic [PSW-1:0] HdrEnd = PSW'(P - 1);
  localparam logic [PSW-1:0] TagEnd = PSW'(P);
  localparam logic [PSW-1:0] TagTop = PSW'(P - 1);

  abad_pkg::state_e  state_q, state_d;
  abad_pkg::phase_e  phase_q, phase_d;
  logic [P-1:0]      lo_q, lo_d, hi_q, hi_d, tag_q, tag_d;
  logic [CW-1:0]     c0_q, c0_d, c1_q, c1_d;
  logic [SLW-1:0]    left_q, left_d;
  logic [HW-1:0]     hdr_q, hdr_d;
  logic [PSW-1:0]    pos_q, pos_d;
  logic              err_q, err_d, sym_q, sym_d, vld_q, vld_d, last_q, last_d;
  logic              k_q, k_d;
  logic [RW-1:0]     range_q, range_d;
  logic [TW-1:0]     total_q, total_d;
  logic              out_valid_q, out_valid_d;
  abad_pkg::out_t    out_q, out_d;
  logic [abad_pkg::InitW-1:0] icz_q, ico_q;
  logic [abad_pkg::CfgDataW-1:0] maxt_q;

  abad_pkg::arith_req_t areq;
  logic [PW-1:0]     a_op, a_res;
  logic [DW-1:0]     b_op;
  logic              a_done;

  abad_arith #(.PW(PW), .DW(DW)) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (areq),
    .a_i    (a_op),
    .b_i    (b_op),
    .res_o  (a_res),
    .done_o (a_done)
  );

  logic              in_ready, has_bit, e12, e3;
  abad_pkg::phase_e  ph;
  logic [PSW-1:0]    pos;
  logic [HW-1:0]     hdr, hdr_new;
  logic [TW-1:0]     total, csum;
  logic [RW-1:0]     q2, lo_add, hi_add;
  logic [RW:0]       hi_sum;

  assign in_ready = (state_q == abad_pkg::ST_IDLE) && !out_valid_q;
  assign has_bit  = !in_data_i.mode;
  assign e12      = hi_q[P-1] == lo_q[P-1];
  assign e3       = !hi_q[P-2] && lo_q[P-2];

  always_comb begin
    state_d = state_q; phase_d = phase_q;
    lo_d = lo_q; hi_d = hi_q; tag_d = tag_q; c0_d = c0_q; c1_d = c1_q;
    left_d = left_q; hdr_d = hdr_q; pos_d = pos_q; err_d = err_q;
    sym_d = sym_q; vld_d = vld_q; last_d = last_q; k_d = k_q;
    range_d = range_q; total_d = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    areq = '0; a_op = '0; b_op = '0;
    ph = phase_q; pos = pos_q; hdr = hdr_q; hdr_new = hdr_q;
    total = TW'(c0_q) + TW'(c1_q);
    csum = TW'(c0_q) + TW'(c1_q);
    q2 = a_res[RW-1:0];
    lo_add = k_q ? q2 : '0;
    hi_add = k_q ? range_q : q2;
    hi_sum = {2'b00, lo_q} + {1'b0, hi_add} - 1'b1;
    case (state_q)
      abad_pkg::ST_IDLE: begin
        if (in_valid_i && in_ready) begin
          sym_d = 1'b0; vld_d = 1'b0; last_d = 1'b0;
          state_d = abad_pkg::ST_FIN;
          if (in_data_i.start_req) begin
            lo_d = '0; hi_d = '1; tag_d = '0;
            c0_d = CW'(icz_q); c1_d = CW'(ico_q);
            left_d = '0; hdr = '0; pos = '0; err_d = 1'b0;
            ph = abad_pkg::PH_HEADER; phase_d = abad_pkg::PH_HEADER;
            hdr_d = '0; pos_d = '0;
          end
          hdr_new = hdr | (HW'(in_data_i.coded_bit) << pos);
          case (ph)
            abad_pkg::PH_HEADER: begin
              if (has_bit) begin
                hdr_d = hdr_new;
                if (pos + 1'b1 >= HdrEnd) begin
                  left_d = {hdr_new, 3'b000};
                  pos_d = '0;
                  phase_d = abad_pkg::PH_TAG;
                end else begin
                  pos_d = pos + 1'b1;
                end
              end
            end
            abad_pkg::PH_TAG: begin
              if (has_bit) begin
                tag_d = tag_q | (P'(in_data_i.coded_bit) << (TagTop - pos));
                if (pos + 1'b1 >= TagEnd) begin
                  pos_d = '0;
                  phase_d = (left_q == '0) ? abad_pkg::PH_IDLE : abad_pkg::PH_DECODE;
                end else begin
                  pos_d = pos + 1'b1;
                end
              end
            end
            abad_pkg::PH_DECODE: begin
              if (e12 || e3) begin
                if (has_bit) begin
                  lo_d  = {lo_q[P-2:0], 1'b0};
                  hi_d  = {hi_q[P-2:0], 1'b1};
                  tag_d = {tag_q[P-2:0], in_data_i.coded_bit};
                  if (!e12) begin
                    // e3 rescale flips the top bit of all three
                    lo_d[P-1]  = ~lo_q[P-2];
                    hi_d[P-1]  = ~hi_q[P-2];
                    tag_d[P-1] = ~tag_q[P-2];
                  end
                end
              end else begin
                state_d = abad_pkg::ST_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      abad_pkg::ST_CHECK: begin
        if (hi_q < lo_q || tag_q < lo_q || tag_q > hi_q || total == '0) begin
          err_d = 1'b1; phase_d = abad_pkg::PH_IDLE;
          state_d = abad_pkg::ST_FIN;
        end else begin
          range_d = RW'(hi_q) - RW'(lo_q) + 1'b1;
          total_d = total;
          areq = '{start: 1'b1, op: abad_pkg::OP_MUL};
          a_op = PW'(RW'(tag_q) - RW'(lo_q) + 1'b1);
          b_op = DW'(total);
          state_d = abad_pkg::ST_MUL1;
        end
      end
      abad_pkg::ST_MUL1: begin
        if (a_done) begin
          areq = '{start: 1'b1, op: abad_pkg::OP_DIV};
          a_op = a_res - 1'b1;
          b_op = DW'(range_q);
          state_d = abad_pkg::ST_DIV1;
        end
      end
      abad_pkg::ST_DIV1: begin
        if (a_done) begin
          if (a_res >= PW'(total_q)) begin
            err_d = 1'b1; phase_d = abad_pkg::PH_IDLE;
            state_d = abad_pkg::ST_FIN;
          end else begin
            k_d = a_res >= PW'(c0_q);
            areq = '{start: 1'b1, op: abad_pkg::OP_MUL};
            a_op = PW'(range_q);
            b_op = DW'(c0_q);
            state_d = abad_pkg::ST_MUL2;
          end
        end
      end
      abad_pkg::ST_MUL2: begin
        if (a_done) begin
          areq = '{start: 1'b1, op: abad_pkg::OP_DIV};
          a_op = a_res;
          b_op = DW'(total_q);
          state_d = abad_pkg::ST_DIV2;
        end
      end
      abad_pkg::ST_DIV2: begin
        if (a_done) begin
          hi_d = hi_sum[P-1:0];
          lo_d = P'(RW'(lo_q) + lo_add);
          if (k_q) c1_d = c1_q + 1'b1;
          else c0_d = c0_q + 1'b1;
          state_d = abad_pkg::ST_NORM;
        end
      end
      abad_pkg::ST_NORM: begin
        if (csum > TW'(maxt_q)) begin
          c0_d = CW'((TW'(c0_q) + 1'b1) >> 1);
          c1_d = CW'((TW'(c1_q) + 1'b1) >> 1);
        end
        sym_d = k_q; vld_d = 1'b1;
        left_d = left_q - 1'b1;
        if (left_q == SLW'(1)) begin
          last_d = 1'b1; phase_d = abad_pkg::PH_IDLE;
        end
        state_d = abad_pkg::ST_FIN;
      end
      abad_pkg::ST_FIN: begin
        out_valid_d = 1'b1;
        out_d.symbol = sym_q;
        out_d.symbol_valid = vld_q;
        out_d.last = last_q;
        out_d.error = err_q;
        case (phase_q)
          abad_pkg::PH_HEADER, abad_pkg::PH_TAG: out_d.need_bit = 1'b1;
          abad_pkg::PH_DECODE: out_d.need_bit = e12 || e3;
          default: out_d.need_bit = 1'b0;
        endcase
        state_d = abad_pkg::ST_IDLE;
      end
      default: state_d = abad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abad_pkg::ST_IDLE; phase_q <= abad_pkg::PH_IDLE;
      lo_q <= '0; hi_q <= '1; tag_q <= '0;
      c0_q <= CW'(1); c1_q <= CW'(1);
      left_q <= '0; hdr_q <= '0; pos_q <= '0; err_q <= 1'b0;
      sym_q <= 1'b0; vld_q <= 1'b0; last_q <= 1'b0; k_q <= 1'b0;
      range_q <= '0; total_q <= '0;
      out_valid_q <= 1'b0; out_q <= '0;
    end else begin
      state_q <= state_d; phase_q <= phase_d;
      lo_q <= lo_d; hi_q <= hi_d; tag_q <= tag_d;
      c0_q <= c0_d; c1_q <= c1_d;
      left_q <= left_d; hdr_q <= hdr_d; pos_q <= pos_d; err_q <= err_d;
      sym_q <= sym_d; vld_q <= vld_d; last_q <= last_d; k_q <= k_d;
      range_q <= range_d; total_q <= total_d;
      out_valid_q <= out_valid_d; out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icz_q <= abad_pkg::InitW'(1);
      ico_q <= abad_pkg::InitW'(1);
      maxt_q <= abad_pkg::CfgDataW'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        abad_pkg::CFG_COUNT_ZERO: icz_q <= cfg_data_i[abad_pkg::InitW-1:0];
        abad_pkg::CFG_COUNT_ONE:  ico_q <= cfg_data_i[abad_pkg::InitW-1:0];
        abad_pkg::CFG_MAX_TOTAL:  maxt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_done |-> (state_q == abad_pkg::ST_MUL1 || state_q == abad_pkg::ST_DIV1 ||
                state_q == abad_pkg::ST_MUL2 || state_q == abad_pkg::ST_DIV2))
    else $error("arith done outside a wait state");
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last |-> out_q.symbol_valid && !out_q.error)
    else $error("last without a clean symbol");
  a_decode_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == abad_pkg::PH_DECODE |-> left_q != '0)
    else $error("decoding with no symbols left");
  a_fin_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == abad_pkg::ST_FIN |=> out_valid_q && state_q == abad_pkg::ST_IDLE)
    else $error("result not loaded after finish");
`endif

endmodule
`default_nettype wire
